>>> rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// shared types and constants of the stable minimum priority queue
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned OccW        = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ValueW-1:0]      value;
    logic signed [KeyW-1:0] key;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } cell_ctrl_t;

endpackage

>>> rtl/stable_min_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// result registered in the cycle after the input transaction
// throughput: one insert or pop per cycle, all cells compare in parallel
// a result waiting on the output stalls input only if it is not taken
// reset clears the entry count and the output valid; cell contents are
// not cleared and are never read before being written
// ----------------------------------------------------------------------------
module stable_min_priority_queue #(
  parameter int unsigned CAPACITY = smpq_pkg::CapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // entry_value[31:0], entry_key[63:32]
  input  logic [0:0]  s_axis_tuser,   // opcode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_value[31:0], out_key[63:32],
                                      // occupancy[68:64], zero[71:69]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [1:0]      status_q, status_d;
  smpq_pkg::entry_t res_q, res_d;
  logic [smpq_pkg::OccW-1:0] occ_q;

  logic is_full, is_empty, accept, is_pop;
  smpq_pkg::cell_ctrl_t ctrl;

  smpq_pkg::entry_t cell_entry [CAPACITY];
  logic             cell_take  [CAPACITY];

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_pop   = (s_axis_tuser[0] == smpq_pkg::OP_POP);
  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);

  assign ctrl.ins       = accept && !is_pop && !is_full;
  assign ctrl.pop       = accept && is_pop && !is_empty;
  assign ctrl.ent.value = s_axis_tdata[31:0];
  assign ctrl.ent.key   = s_axis_tdata[63:32];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    smpq_pkg::entry_t left, right;
    logic             left_take, occ;

    assign occ = (count_q > CntW'(g));

    if (g == 0) begin : g_head
      assign left      = cell_entry[g];
      assign left_take = 1'b0;
    end else begin : g_body
      assign left      = cell_entry[g-1];
      assign left_take = cell_take[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right = cell_entry[g];
    end else begin : g_mid
      assign right = cell_entry[g+1];
    end

    smpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .left_i      (left),
      .left_take_i (left_take),
      .right_i     (right),
      .entry_o     (cell_entry[g]),
      .take_o      (cell_take[g])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = smpq_pkg::ST_OK;
    res_d    = '0;
    if (ctrl.ins) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop) begin
      count_d = count_q - 1'b1;
      res_d   = cell_entry[0];
    end
    if (accept && is_pop && is_empty) begin
      status_d = smpq_pkg::ST_EMPTY;
    end else if (accept && !is_pop && is_full) begin
      status_d = smpq_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      res_q    <= res_d;
      occ_q    <= smpq_pkg::OccW'(count_d);
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {3'b000, occ_q, res_q.key, res_q.value};

endmodule

>>> rtl/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell
// one slot of the sorted shift-register queue
// ----------------------------------------------------------------------------
module smpq_cell (
  input  logic                 clk_i,
  input  smpq_pkg::cell_ctrl_t ctrl_i,
  input  logic                 occ_i,
  input  smpq_pkg::entry_t     left_i,
  input  logic                 left_take_i,
  input  smpq_pkg::entry_t     right_i,
  output smpq_pkg::entry_t     entry_o,
  output logic                 take_o
);

  smpq_pkg::entry_t entry_q, entry_d;

  // new entry belongs here or before: slot empty or new key strictly smaller
  assign take_o  = !occ_i || (ctrl_i.ent.key < entry_q.key);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && take_o) begin
      entry_d = left_take_i ? left_i : ctrl_i.ent;
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
